// ----- rtl/sxdf_pkg.sv -----
// Shared types and constants for the SysEx chunk deframer.
// Used by sxdf_step and sysex_chunk_deframer_7to8; depends on nothing else.
package sxdf_pkg;

    localparam logic [7:0] END_BYTE     = 8'hF7;
    localparam logic [7:0] START_BYTE   = 8'hF0;
    localparam logic [7:0] START_SECOND = 8'h01;
    localparam logic [6:0] CMD_MULTI_A  = 7'h01;
    localparam logic [6:0] CMD_MULTI_B  = 7'h03;
    localparam logic [6:0] SUB_MULTI    = 7'h01;
    localparam logic [7:0] HIGH_BIT     = 8'h80;

    typedef enum logic [2:0] {
        HDR_START  = 3'd0,
        HDR_SECOND = 3'd1,
        HDR_SEQ    = 3'd2,
        HDR_SKIP   = 3'd3,
        HDR_CMD    = 3'd4,
        HDR_SUB    = 3'd5,
        HDR_DATA   = 3'd6
    } hdr_pos_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_EOM  = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef struct packed {
        hdr_pos_t    hdr_pos;
        logic [2:0]  group_idx;
        logic [6:0]  mask;
        logic [6:0]  cmd;
        logic [6:0]  sub;
        logic [6:0]  seq;
        logic [1:0]  dec_count;
        logic [7:0]  chunk_total;
        logic [7:0]  chunk_index;
        logic        discarding;
    } dfr_state_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  payload;
        logic [6:0]  cmd;
        logic [6:0]  sub;
        logic [6:0]  seq;
    } dfr_result_t;

endpackage

// ----- rtl/sxdf_step.sv -----
// Next-state and result logic for one stream byte of the deframer.
// Purely combinational; uses the types and constants of sxdf_pkg.
module sxdf_step
(
    input  sxdf_pkg::dfr_state_t  state,
    input  logic [7:0]            stream_byte,
    output sxdf_pkg::dfr_state_t  state_next,
    output sxdf_pkg::dfr_result_t result
);

    logic [2:0] bit_idx;
    logic       mask_bit;
    logic [7:0] dec_val;
    logic       is_multi;
    logic       multi_done;

    assign bit_idx  = state.group_idx - 3'd1;
    assign mask_bit = state.mask[bit_idx];
    assign dec_val  = mask_bit ? (stream_byte | sxdf_pkg::HIGH_BIT) : stream_byte;
    assign is_multi = ((state.cmd == sxdf_pkg::CMD_MULTI_A) ||
                       (state.cmd == sxdf_pkg::CMD_MULTI_B)) &&
                      (state.sub == sxdf_pkg::SUB_MULTI);
    assign multi_done = (state.dec_count >= 2'd2) &&
                        (state.chunk_index == (state.chunk_total - 8'd1));

    always_comb
    begin
        state_next     = state;
        result.valid   = 1'b0;
        result.kind    = sxdf_pkg::KIND_DATA;
        result.payload = 8'd0;
        result.cmd     = 7'd0;
        result.sub     = 7'd0;
        result.seq     = 7'd0;

        if (state.discarding)
        begin
            if (stream_byte == sxdf_pkg::END_BYTE)
            begin
                state_next.discarding = 1'b0;
                state_next.hdr_pos    = sxdf_pkg::HDR_START;
            end
        end
        else
        begin
            case (state.hdr_pos)
                sxdf_pkg::HDR_START,
                sxdf_pkg::HDR_SECOND:
                begin
                    if ((state.hdr_pos == sxdf_pkg::HDR_START &&
                         stream_byte == sxdf_pkg::START_BYTE) ||
                        (state.hdr_pos == sxdf_pkg::HDR_SECOND &&
                         stream_byte == sxdf_pkg::START_SECOND))
                    begin
                        state_next.hdr_pos = (state.hdr_pos == sxdf_pkg::HDR_START) ?
                                             sxdf_pkg::HDR_SECOND : sxdf_pkg::HDR_SEQ;
                    end
                    else
                    begin
                        state_next.hdr_pos    = sxdf_pkg::HDR_START;
                        state_next.discarding = (stream_byte != sxdf_pkg::END_BYTE);
                        result.valid          = 1'b1;
                        result.kind           = sxdf_pkg::KIND_BAD;
                    end
                end
                sxdf_pkg::HDR_SEQ,
                sxdf_pkg::HDR_SKIP,
                sxdf_pkg::HDR_CMD,
                sxdf_pkg::HDR_SUB:
                begin
                    if (stream_byte == sxdf_pkg::END_BYTE)
                    begin
                        state_next.hdr_pos = sxdf_pkg::HDR_START;
                    end
                    else
                    begin
                        case (state.hdr_pos)
                            sxdf_pkg::HDR_SEQ:
                            begin
                                state_next.seq     = stream_byte[6:0];
                                state_next.hdr_pos = sxdf_pkg::HDR_SKIP;
                            end
                            sxdf_pkg::HDR_SKIP:
                            begin
                                state_next.hdr_pos = sxdf_pkg::HDR_CMD;
                            end
                            sxdf_pkg::HDR_CMD:
                            begin
                                state_next.cmd     = stream_byte[6:0];
                                state_next.hdr_pos = sxdf_pkg::HDR_SUB;
                            end
                            default:
                            begin
                                state_next.sub       = stream_byte[6:0];
                                state_next.group_idx = 3'd0;
                                state_next.mask      = 7'd0;
                                state_next.dec_count = 2'd0;
                                state_next.hdr_pos   = sxdf_pkg::HDR_DATA;
                            end
                        endcase
                    end
                end
                sxdf_pkg::HDR_DATA:
                begin
                    if (stream_byte == sxdf_pkg::END_BYTE)
                    begin
                        state_next.hdr_pos = sxdf_pkg::HDR_START;
                        if (!is_multi || multi_done)
                        begin
                            result.valid = 1'b1;
                            result.kind  = sxdf_pkg::KIND_EOM;
                            result.cmd   = state.cmd;
                            result.sub   = state.sub;
                            result.seq   = state.seq;
                        end
                    end
                    else if (state.group_idx == 3'd0)
                    begin
                        state_next.mask      = stream_byte[6:0];
                        state_next.group_idx = 3'd1;
                    end
                    else
                    begin
                        state_next.group_idx = state.group_idx + 3'd1;
                        if (state.dec_count != 2'd3)
                        begin
                            state_next.dec_count = state.dec_count + 2'd1;
                        end
                        if (is_multi && state.dec_count != 2'd3)
                        begin
                            if (state.dec_count == 2'd0)
                            begin
                                state_next.chunk_total = dec_val;
                            end
                            else if (state.dec_count == 2'd1)
                            begin
                                state_next.chunk_index = dec_val;
                            end
                        end
                        else
                        begin
                            result.valid   = 1'b1;
                            result.kind    = sxdf_pkg::KIND_DATA;
                            result.payload = dec_val;
                            result.cmd     = state.cmd;
                            result.sub     = state.sub;
                            result.seq     = state.seq;
                        end
                    end
                end
                default:
                begin
                    state_next.hdr_pos = sxdf_pkg::HDR_START;
                end
            endcase
        end
    end

endmodule

// ----- rtl/sysex_chunk_deframer_7to8.sv -----
// Top level of the SysEx chunk deframer with 7-bit to 8-bit unpacking.
// Depends on sxdf_pkg and instantiates sxdf_step.
//
// Usage: raw stream bytes enter on the input channel (in_valid, in_ready,
// stream_byte), one byte per transaction. Chunks run from F0 01 through
// sequence, spare, command and subcommand bytes to a closing F7. Results
// leave on the output channel (out_valid, out_ready) with kind, payload,
// command, subcommand and sequence_res. A byte yields zero or one result.
// An accepted byte sits in an input register; on the next edge at which
// the result register is free or being drained, the byte is decoded and
// its result, if any, is loaded. A result reaches out_valid by way of the
// input register and then the result register, and one byte per cycle is
// sustained while the receiver keeps out_ready high. The decode step is a
// single pass of small compares and counter updates on the chunk state.
// When the receiver stalls, one finished result waits in the result
// register and one more byte is still taken into the input register;
// after that in_ready drops until the result is taken. Bytes that give no
// result pass through even while the result register is full.
// Reset clears the chunk state, so the block then awaits an F0, and
// empties both registers.
module sysex_chunk_deframer_7to8
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload,
    output logic [6:0]  command,
    output logic [6:0]  subcommand,
    output logic [6:0]  sequence_res
);

    sxdf_pkg::dfr_state_t  state_reg;
    sxdf_pkg::dfr_state_t  state_next;
    sxdf_pkg::dfr_result_t step_result;
    sxdf_pkg::dfr_result_t res_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  advance;

    sxdf_step u_step
    (
        .state       (state_reg),
        .stream_byte (in_byte_reg),
        .state_next  (state_next),
        .result      (step_result)
    );

    assign advance  = in_valid_reg &&
                      (!res_reg.valid || out_ready || !step_result.valid);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= stream_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (advance && step_result.valid)
        begin
            res_reg <= step_result;
        end
        else if (out_ready)
        begin
            res_reg.valid <= 1'b0;
        end
    end

    assign out_valid    = res_reg.valid;
    assign kind         = res_reg.kind;
    assign payload      = res_reg.payload;
    assign command      = res_reg.cmd;
    assign subcommand   = res_reg.sub;
    assign sequence_res = res_reg.seq;

`ifndef SYNTH
    a_discard_awaits_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.discarding |-> (state_reg.hdr_pos == sxdf_pkg::HDR_START))
        else $error("Discarding while not awaiting a chunk start.");

    a_bad_has_no_header: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == sxdf_pkg::KIND_BAD) |->
        (payload == 8'd0 && command == 7'd0 && subcommand == 7'd0 &&
         sequence_res == 7'd0))
        else $error("Bad chunk start result carries header or payload bits.");

    a_eom_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == sxdf_pkg::KIND_EOM) |-> (payload == 8'd0))
        else $error("End of message result carries a payload.");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && res_reg.valid && !out_ready && step_result.valid) |->
        !in_ready)
        else $error("Input taken while a pending result cannot be stored.");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_result.valid) |=> out_valid)
        else $error("Decoded result was not presented on the output.");
`endif

endmodule

// ----- verif/tb_sysex_chunk_deframer_7to8.sv -----
// Self-checking testbench for sysex_chunk_deframer_7to8: a directed table, then random
// chunk traffic, each byte decoded by an in-bench predictor and compared in order.
// Depends on sxdf_pkg and the RTL of sysex_chunk_deframer_7to8.
module tb_sysex_chunk_deframer_7to8;

    typedef struct packed {
        sxdf_pkg::kind_t kind;
        logic [7:0]  payload;
        logic [6:0]  cmd;
        logic [6:0]  sub;
        logic [6:0]  seq;
    } deframed_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        typed;
        deframed_t   res;
    } stim_row_t;

    localparam deframed_t NONE = '0;
    localparam int N_OPENING = 29;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  stream_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [6:0]  command;
    logic [6:0]  subcommand;
    logic [6:0]  sequence_res;

    sxdf_pkg::hdr_pos_t at_pos;
    logic [2:0]  grp;
    logic [6:0]  hmask;
    logic [6:0]  cur_cmd;
    logic [6:0]  cur_sub;
    logic [6:0]  cur_seq;
    logic [1:0]  n_decoded;
    logic [7:0]  msg_total;
    logic [7:0]  msg_index;
    bit          skipping;

    deframed_t   due_results [$];
    deframed_t   seen;
    deframed_t   oldest;
    logic [7:0]  body [$];
    bit          quiet;
    int          live_bytes;
    int          errors = 0;

    stim_row_t opening [N_OPENING] = '{
        '{8'h00,                  1'b1, '{sxdf_pkg::KIND_BAD,  8'h00, 7'h00, 7'h00, 7'h00}},
        '{sxdf_pkg::END_BYTE,     1'b0, NONE},
        '{sxdf_pkg::END_BYTE,     1'b1, '{sxdf_pkg::KIND_BAD,  8'h00, 7'h00, 7'h00, 7'h00}},
        '{sxdf_pkg::START_BYTE,   1'b0, NONE},
        '{8'h80,                  1'b1, '{sxdf_pkg::KIND_BAD,  8'h00, 7'h00, 7'h00, 7'h00}},
        '{sxdf_pkg::START_BYTE,   1'b0, NONE},
        '{sxdf_pkg::END_BYTE,     1'b0, NONE},
        '{sxdf_pkg::START_BYTE,   1'b0, NONE},
        '{sxdf_pkg::START_SECOND, 1'b0, NONE},
        '{sxdf_pkg::END_BYTE,     1'b0, NONE},
        '{sxdf_pkg::START_BYTE,   1'b0, NONE},
        '{sxdf_pkg::START_SECOND, 1'b0, NONE},
        '{8'hFF,                  1'b0, NONE},
        '{8'h00,                  1'b0, NONE},
        '{8'hFF,                  1'b0, NONE},
        '{8'h7F,                  1'b0, NONE},
        '{8'h7F,                  1'b0, NONE},
        '{8'h00,                  1'b1, '{sxdf_pkg::KIND_DATA, 8'h80, 7'h7F, 7'h7F, 7'h7F}},
        '{sxdf_pkg::START_BYTE,   1'b1, '{sxdf_pkg::KIND_DATA, 8'hF0, 7'h7F, 7'h7F, 7'h7F}},
        '{sxdf_pkg::END_BYTE,     1'b1, '{sxdf_pkg::KIND_EOM,  8'h00, 7'h7F, 7'h7F, 7'h7F}},
        '{sxdf_pkg::START_BYTE,   1'b0, NONE},
        '{sxdf_pkg::START_SECOND, 1'b0, NONE},
        '{8'h00,                  1'b0, NONE},
        '{8'h00,                  1'b0, NONE},
        '{8'h03,                  1'b0, NONE},
        '{8'h01,                  1'b0, NONE},
        '{8'h00,                  1'b0, NONE},
        '{8'h01,                  1'b0, NONE},
        '{sxdf_pkg::END_BYTE,     1'b0, NONE}
    };

    sysex_chunk_deframer_7to8 dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .stream_byte  (stream_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload      (payload),
        .command      (command),
        .subcommand   (subcommand),
        .sequence_res (sequence_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb_sysex_chunk_deframer_7to8: done, errors");
        $finish;
    end

    function automatic int unsigned draw_wait();
        if (quiet || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] not_end();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == sxdf_pkg::END_BYTE)
            b = 8'h77;
        return b;
    endfunction

    function automatic bit multi_msg();
        return ((cur_cmd == sxdf_pkg::CMD_MULTI_A) || (cur_cmd == sxdf_pkg::CMD_MULTI_B)) &&
               (cur_sub == sxdf_pkg::SUB_MULTI);
    endfunction

    task automatic decode_byte(input logic [7:0] b, output bit got, output deframed_t r);
        logic [7:0] val;
        got = 1'b0;
        r = NONE;
        if (skipping)
        begin
            if (b == sxdf_pkg::END_BYTE)
            begin
                skipping = 1'b0;
                at_pos = sxdf_pkg::HDR_START;
            end
        end
        else if (at_pos == sxdf_pkg::HDR_START || at_pos == sxdf_pkg::HDR_SECOND)
        begin
            if (b == ((at_pos == sxdf_pkg::HDR_START) ? sxdf_pkg::START_BYTE :
                                                        sxdf_pkg::START_SECOND))
                at_pos = sxdf_pkg::hdr_pos_t'(at_pos + 3'd1);
            else
            begin
                at_pos = sxdf_pkg::HDR_START;
                skipping = (b != sxdf_pkg::END_BYTE);
                got = 1'b1;
                r.kind = sxdf_pkg::KIND_BAD;
            end
        end
        else if (at_pos != sxdf_pkg::HDR_DATA)
        begin
            if (b == sxdf_pkg::END_BYTE)
                at_pos = sxdf_pkg::HDR_START;
            else
            begin
                case (at_pos)
                    sxdf_pkg::HDR_SEQ: cur_seq = b[6:0];
                    sxdf_pkg::HDR_CMD: cur_cmd = b[6:0];
                    sxdf_pkg::HDR_SUB:
                    begin
                        cur_sub = b[6:0];
                        grp = 3'd0;
                        hmask = 7'd0;
                        n_decoded = 2'd0;
                    end
                    default: ;
                endcase
                at_pos = sxdf_pkg::hdr_pos_t'(at_pos + 3'd1);
            end
        end
        else if (b == sxdf_pkg::END_BYTE)
        begin
            at_pos = sxdf_pkg::HDR_START;
            if (!multi_msg() || (n_decoded >= 2'd2 && msg_index == msg_total - 8'd1))
            begin
                got = 1'b1;
                r = '{sxdf_pkg::KIND_EOM, 8'h00, cur_cmd, cur_sub, cur_seq};
            end
        end
        else if (grp == 3'd0)
        begin
            hmask = b[6:0];
            grp = 3'd1;
        end
        else
        begin
            val = b | (hmask[grp - 3'd1] ? sxdf_pkg::HIGH_BIT : 8'h00);
            grp = grp + 3'd1;
            if (multi_msg() && n_decoded != 2'd3)
            begin
                if (n_decoded == 2'd0)
                    msg_total = val;
                else if (n_decoded == 2'd1)
                    msg_index = val;
                n_decoded = n_decoded + 2'd1;
            end
            else
            begin
                if (n_decoded != 2'd3)
                    n_decoded = n_decoded + 2'd1;
                got = 1'b1;
                r = '{sxdf_pkg::KIND_DATA, val, cur_cmd, cur_sub, cur_seq};
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed, input deframed_t typed_res);
        int unsigned gap;
        bit          got;
        deframed_t   r;
        gap = draw_wait();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        live_bytes++;
        decode_byte(b, got, r);
        if (typed)
            due_results.insert(due_results.size(), typed_res);
        else if (got)
            due_results.insert(due_results.size(), r);
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, 1'b0, NONE);
    endtask

    task automatic send_chunk(input logic [7:0] seq_b, input logic [7:0] cmd_b,
                              input logic [7:0] sub_b, input bit closed);
        logic [7:0] mb;
        logic [7:0] raw;
        int         n;
        send_plain(sxdf_pkg::START_BYTE);
        send_plain(sxdf_pkg::START_SECOND);
        send_plain(seq_b);
        send_plain(not_end());
        send_plain(cmd_b);
        send_plain(sub_b);
        if (body.size() == 0 && $urandom_range(0, 1) == 0)
            send_plain(not_end());
        for (int g = 0; g < body.size(); g += 7)
        begin
            n = (body.size() - g < 7) ? body.size() - g : 7;
            mb = 8'($urandom_range(0, 255));
            for (int j = 0; j < n; j++)
                mb[j] = body[g + j][7];
            if (mb == sxdf_pkg::END_BYTE)
                mb[7] = 1'b0;
            send_plain(mb);
            for (int j = 0; j < n; j++)
            begin
                raw = body[g + j];
                if (raw == sxdf_pkg::END_BYTE || $urandom_range(0, 1) == 0)
                    raw[7] = 1'b0;
                send_plain(raw);
            end
        end
        if (closed)
            send_plain(sxdf_pkg::END_BYTE);
    endtask

    task automatic send_message();
        int unsigned pick;
        int unsigned total;
        int unsigned n;
        int unsigned cut;
        logic [7:0]  seq_b;
        logic        hb_cmd;
        logic        hb_sub;
        quiet = ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 9);
        seq_b = not_end();
        if (pick < 4)
        begin
            body.delete();
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 22) : $urandom_range(0, 7);
            repeat (n) body.insert(body.size(), 8'($urandom_range(0, 255)));
            send_chunk(seq_b, not_end(), not_end(), 1'b1);
        end
        else if (pick < 7)
        begin
            total = $urandom_range(1, 4);
            hb_cmd = 1'($urandom_range(0, 1));
            hb_sub = 1'($urandom_range(0, 1));
            for (int idx = 0; idx < total; idx++)
            begin
                body.delete();
                body.insert(body.size(), 8'(($urandom_range(0, 9) == 0) ?
                                            $urandom_range(0, 255) : total));
                body.insert(body.size(), 8'(idx));
                body.insert(body.size(), 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 8))
                    body.insert(body.size(), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0)
                begin
                    cut = $urandom_range(0, 2);
                    while (body.size() > cut) body.delete(body.size() - 1);
                end
                send_chunk(seq_b,
                           {hb_cmd, ($urandom_range(0, 1) == 0) ? sxdf_pkg::CMD_MULTI_A :
                                                                  sxdf_pkg::CMD_MULTI_B},
                           {hb_sub, sxdf_pkg::SUB_MULTI}, 1'b1);
            end
        end
        else if (pick < 9)
        begin
            case ($urandom_range(0, 2))
                0: repeat ($urandom_range(1, 4)) send_plain(8'($urandom_range(0, 255)));
                1:
                begin
                    send_plain(sxdf_pkg::START_BYTE);
                    send_plain(sxdf_pkg::START_SECOND);
                    repeat ($urandom_range(0, 3)) send_plain(not_end());
                    send_plain(sxdf_pkg::END_BYTE);
                end
                default:
                begin
                    body.delete();
                    repeat ($urandom_range(0, 5))
                        body.insert(body.size(), 8'($urandom_range(0, 255)));
                    send_chunk(seq_b, not_end(), not_end(), 1'b0);
                end
            endcase
        end
        else
        begin
            send_plain(($urandom_range(0, 1) == 0) ? sxdf_pkg::END_BYTE : sxdf_pkg::START_BYTE);
            send_plain(8'($urandom_range(0, 255)));
            send_plain(sxdf_pkg::END_BYTE);
        end
    endtask

    task automatic flag_error(input string what, input deframed_t want, input deframed_t got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: expected kind=%0d payload=%02h cmd=%02h sub=%02h seq=%02h",
                     $realtime, what, want.kind, want.payload, want.cmd, want.sub, want.seq,
                     "\n    actual kind=%0d payload=%02h cmd=%02h sub=%02h seq=%02h",
                     got.kind, got.payload, got.cmd, got.sub, got.seq);
    endtask

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready === 1'b1)
        begin
            seen = '{sxdf_pkg::kind_t'(kind), payload, command, subcommand, sequence_res};
            if (due_results.size() == 0)
                flag_error("unexpected transaction", NONE, seen);
            else
            begin
                oldest = due_results.pop_front();
                if (kind !== oldest.kind || payload !== oldest.payload ||
                    command !== oldest.cmd || subcommand !== oldest.sub ||
                    sequence_res !== oldest.seq)
                    flag_error("mismatch", oldest, seen);
            end
        end
    end

    initial
    begin : drain
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
        end
    end

    initial
    begin : feed
        rst_n = 1'b0;
        in_valid = 1'b0;
        stream_byte = 8'h00;
        quiet = 1'b0;
        live_bytes = 0;
        at_pos = sxdf_pkg::HDR_START;
        grp = 3'd0;
        hmask = 7'd0;
        cur_cmd = 7'd0;
        cur_sub = 7'd0;
        cur_seq = 7'd0;
        n_decoded = 2'd0;
        msg_total = 8'd0;
        msg_index = 8'd0;
        skipping = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (opening[i])
            send_byte(opening[i].b, opening[i].typed, opening[i].res);
        while (live_bytes < 450)
            send_message();
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb_sysex_chunk_deframer_7to8: done, clean");
        else
            $display("tb_sysex_chunk_deframer_7to8: done, errors");
        $finish;
    end

endmodule
